// ===== hdl/gpm_pkg.sv =====
// gpm_pkg: shared types, codes and constants of the glob pattern matcher.
// Used by gpm_front, gpm_back and glob_pattern_matcher_unit.
// No dependencies.
package gpm_pkg;

  localparam int PATTERN_LEN_DEF = 64;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CP_W            = 21;
  localparam int IN_TDATA_W      = 24;
  localparam int OUT_TDATA_W     = 8;

  localparam logic [CP_W-1:0] CH_STAR  = 21'h00002A;
  localparam logic [CP_W-1:0] CH_OPEN  = 21'h00005B;
  localparam logic [CP_W-1:0] CH_ANY   = 21'h00003F;
  localparam logic [CP_W-1:0] CH_CLOSE = 21'h00005D;
  localparam logic [CP_W-1:0] CH_BANG  = 21'h000021;

  // syntax class of a codepoint, worked out on entry
  typedef enum logic [2:0] {
    CL_OTHER, CL_STAR, CL_ANY, CL_OPEN, CL_CLOSE, CL_BANG
  } cls_t;

  typedef enum logic {CMD_PATTERN = 1'b0, CMD_SUBJECT = 1'b1} cmd_t;
  typedef enum logic {RK_LOAD = 1'b0, RK_VERDICT = 1'b1} kind_t;
  typedef enum logic [1:0] {ST_OK, ST_BANG, ST_OPEN, ST_LONG} load_st_t;

  typedef enum logic {EX_RUN, EX_SWEEP} ex_state_t;

  // pattern parser position: normal, the '!' of '[!', first member, in set,
  // the '!' of "[!]", the ']' of "[!]"
  typedef enum logic [2:0] {
    PS_NORM, PS_NEG, PS_FIRST, PS_SET, PS_SPM, PS_SPC
  } ps_t;

  typedef struct packed {
    cmd_t            cmd;
    logic [CP_W-1:0] cp;
    logic            last;
    logic            empty;
    cls_t            cls;
  } item_t;

  typedef struct packed {
    logic busy;   // issue blocked, pattern being compiled
    logic sweep;  // compile sweep running
  } bk_stat_t;

  function automatic cls_t classify(input logic [CP_W-1:0] cp);
    cls_t r;
    case (cp)
      CH_STAR:  r = CL_STAR;
      CH_ANY:   r = CL_ANY;
      CH_OPEN:  r = CL_OPEN;
      CH_CLOSE: r = CL_CLOSE;
      CH_BANG:  r = CL_BANG;
      default:  r = CL_OTHER;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/gpm_scan.sv =====
// gpm_scan: log-depth generate/propagate prefix scan, c[j] = g[j] | p[j] & c[j-1].
// Used by gpm_back for set membership, element advance and star closure.
// Depends on nothing.
module gpm_scan #(
  parameter int N = 64
) (
  input  logic [N-1:0] g,
  input  logic [N-1:0] p,
  output logic [N-1:0] c
);

  localparam int LV = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] gc, pc, gn, pn;

  always_comb begin
    gc = g;
    pc = p;
    gn = g;
    pn = p;
    for (int lv = 0; lv < LV; lv++) begin
      for (int j = 0; j < N; j++) begin
        if (j >= (1 << lv)) begin
          gn[j] = gc[j] | (pc[j] & gc[j - (1 << lv)]);
          pn[j] = pc[j] & pc[j - (1 << lv)];
        end else begin
          gn[j] = gc[j];
          pn[j] = pc[j];
        end
      end
      gc = gn;
      pc = pn;
    end
    c = gc;
  end

endmodule

// ===== hdl/gpm_front.sv =====
// gpm_front: accepts requests, classifies the codepoint and queues them.
// Depends on gpm_pkg.
module gpm_front #(
  parameter int DEPTH = gpm_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [gpm_pkg::CP_W-1:0]    in_cp,
  input  logic                        in_last,
  input  logic                        in_empty,
  output logic                        q_valid,
  output gpm_pkg::item_t              q_item,
  input  logic                        q_pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  gpm_pkg::item_t qmem [DEPTH];
  gpm_pkg::item_t new_item;
  logic [AW-1:0]  wp;
  logic [AW-1:0]  rp;
  logic [CW-1:0]  cnt;
  logic           push;

  assign in_ready = (cnt != CW'(DEPTH));
  assign q_valid  = (cnt != '0);
  assign q_item   = qmem[rp];
  assign push     = in_valid & in_ready;

  always_comb begin
    new_item.cmd   = gpm_pkg::cmd_t'(in_cmd);
    new_item.cp    = in_cp;
    new_item.last  = in_last;
    new_item.empty = in_empty;
    new_item.cls   = gpm_pkg::classify(in_cp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (q_pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !q_pop) begin
        cnt <= cnt + 1'b1;
      end else if (!push && q_pop) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wp] <= new_item;
    end
  end

endmodule

// ===== hdl/gpm_back.sv =====
// gpm_back: issue pipeline, pattern store and compiler, position-parallel matcher.
// Depends on gpm_pkg and gpm_scan.
module gpm_back #(
  parameter int PATTERN_LEN = gpm_pkg::PATTERN_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  gpm_pkg::item_t      q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output gpm_pkg::kind_t      out_kind,
  output gpm_pkg::load_st_t   out_status,
  output logic                out_matched,
  output gpm_pkg::bk_stat_t   stat
);

  localparam int L  = PATTERN_LEN;
  localparam int LW = $clog2(L + 1);
  localparam int PW = $clog2(L);

  // pattern storage: codepoints compared in parallel, classes shifted by the compiler
  logic [gpm_pkg::CP_W-1:0] store [L];
  gpm_pkg::cls_t            cls_q [L];

  // compiled pattern, one bit per pattern position
  logic [L-1:0] head, star, anyv, neg, member;
  logic [L:0]   act;
  logic [L:0]   bnd;

  logic [LW-1:0] len, rem, eff_len, len_n;
  logic [PW-1:0] pos;
  logic          loading, over, lead_bang, pvalid, busy;
  logic          over_n, lead_bang_n;

  gpm_pkg::ex_state_t state, state_next;
  gpm_pkg::ps_t       pstate, pstate_next;
  gpm_pkg::load_st_t  st_code;

  // pipeline
  logic           v1, v2;
  gpm_pkg::item_t it1, it2;
  logic [L-1:0]   eq_d, eq1, acc_d, acc2;

  logic adv, do_item, is_pat, finish, emit, sweep_step;
  logic w_head, w_star, w_any, w_neg, w_member;

  // scan wiring
  logic [L-1:0] xr, pr, cr;
  logic [L-1:0] fire, stay, ycar;
  logic [L:0]   moved, stepped, starp, stepv, initv, act_upd;

  assign adv   = !out_valid | out_ready;
  assign q_pop = q_valid & adv & !busy;
  assign stat.busy  = busy;
  assign stat.sweep = (state == gpm_pkg::EX_SWEEP);

  // stage 1: compare against every stored codepoint
  always_comb begin
    for (int j = 0; j < L; j++) begin
      eq_d[j] = (store[j] == q_item.cp);
    end
  end

  always_comb begin
    for (int j = 0; j < L; j++) begin
      bnd[j] = head[j] | (len == LW'(j));
    end
    bnd[L] = (len == LW'(L));
  end

  // stage 2: OR of member hits over each element span, scanned high to low
  always_comb begin
    for (int k = 0; k < L; k++) begin
      xr[k] = member[L-1-k] & eq1[L-1-k];
      pr[k] = (k == 0) ? 1'b0 : !bnd[L-k];
    end
    for (int j = 0; j < L; j++) begin
      acc_d[j] = cr[L-1-j];
    end
  end

  gpm_scan #(.N(L)) u_span (.g(xr), .p(pr), .c(cr));

  // matcher step
  always_comb begin
    for (int j = 0; j < L; j++) begin
      fire[j] = head[j] & !star[j] & act[j] & (anyv[j] | (acc2[j] ^ neg[j]));
      stay[j] = act[j] & star[j];
    end
  end

  gpm_scan #(.N(L)) u_carry (.g(fire), .p(~bnd[L-1:0]), .c(ycar));

  always_comb begin
    moved[0] = 1'b0;
    for (int t = 1; t <= L; t++) begin
      moved[t] = bnd[t] & ycar[t-1];
    end
    stepped = {1'b0, stay} | moved;
    starp   = {star, 1'b0};
  end

  gpm_scan #(.N(L + 1)) u_close (.g(stepped), .p(starp), .c(stepv));
  gpm_scan #(.N(L + 1)) u_init  (.g((L + 1)'(1)), .p(starp), .c(initv));

  assign act_upd = (pvalid && !it2.empty) ? stepv : act;

  // load bookkeeping
  always_comb begin
    eff_len     = loading ? len : '0;
    len_n       = eff_len;
    over_n      = loading & over;
    lead_bang_n = loading & lead_bang;
    if (!it2.empty) begin
      if (eff_len < LW'(L)) begin
        len_n = eff_len + 1'b1;
        if (eff_len == '0) begin
          lead_bang_n = (it2.cls == gpm_pkg::CL_BANG);
        end
      end else begin
        over_n = 1'b1;
      end
    end
  end

  always_comb begin
    if (lead_bang) begin
      st_code = gpm_pkg::ST_BANG;
    end else if (over) begin
      st_code = gpm_pkg::ST_LONG;
    end else if (pstate inside {gpm_pkg::PS_FIRST, gpm_pkg::PS_SET}) begin
      st_code = gpm_pkg::ST_OPEN;
    end else begin
      st_code = gpm_pkg::ST_OK;
    end
  end

  // compiler: one pattern position per cycle, lookahead of two
  always_comb begin
    w_head      = 1'b0;
    w_star      = 1'b0;
    w_any       = 1'b0;
    w_neg       = 1'b0;
    w_member    = 1'b0;
    pstate_next = pstate;
    case (pstate)
      gpm_pkg::PS_NORM: begin
        w_head = 1'b1;
        case (cls_q[0])
          gpm_pkg::CL_STAR: w_star = 1'b1;
          gpm_pkg::CL_ANY:  w_any  = 1'b1;
          gpm_pkg::CL_OPEN: begin
            if (rem > LW'(2) && cls_q[1] == gpm_pkg::CL_BANG
                && cls_q[2] == gpm_pkg::CL_CLOSE) begin
              pstate_next = gpm_pkg::PS_SPM;
            end else if (rem > LW'(1) && cls_q[1] == gpm_pkg::CL_BANG) begin
              w_neg       = 1'b1;
              pstate_next = gpm_pkg::PS_NEG;
            end else begin
              pstate_next = gpm_pkg::PS_FIRST;
            end
          end
          default: w_member = 1'b1;
        endcase
      end
      gpm_pkg::PS_NEG:   pstate_next = gpm_pkg::PS_FIRST;
      gpm_pkg::PS_FIRST: begin
        w_member    = 1'b1;
        pstate_next = gpm_pkg::PS_SET;
      end
      gpm_pkg::PS_SET: begin
        if (cls_q[0] == gpm_pkg::CL_CLOSE) begin
          pstate_next = gpm_pkg::PS_NORM;
        end else begin
          w_member = 1'b1;
        end
      end
      gpm_pkg::PS_SPM: begin
        w_member    = 1'b1;
        pstate_next = gpm_pkg::PS_SPC;
      end
      gpm_pkg::PS_SPC: pstate_next = gpm_pkg::PS_NORM;
      default:         pstate_next = gpm_pkg::PS_NORM;
    endcase
  end

  // executor: next state
  always_comb begin
    state_next = state;
    case (state)
      gpm_pkg::EX_RUN: begin
        if (v2 && adv && it2.cmd == gpm_pkg::CMD_PATTERN && it2.last) begin
          state_next = gpm_pkg::EX_SWEEP;
        end
      end
      gpm_pkg::EX_SWEEP: begin
        if (rem == '0 && adv) begin
          state_next = gpm_pkg::EX_RUN;
        end
      end
      default: state_next = gpm_pkg::EX_RUN;
    endcase
  end

  // executor: strobes
  always_comb begin
    do_item    = 1'b0;
    finish     = 1'b0;
    sweep_step = 1'b0;
    case (state)
      gpm_pkg::EX_RUN:   do_item = v2 & adv;
      gpm_pkg::EX_SWEEP: begin
        sweep_step = (rem != '0);
        finish     = (rem == '0) & adv;
      end
      default: do_item = 1'b0;
    endcase
    is_pat = (it2.cmd == gpm_pkg::CMD_PATTERN);
    emit   = (do_item & !is_pat & it2.last) | finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      state     <= gpm_pkg::EX_RUN;
      pstate    <= gpm_pkg::PS_NORM;
      loading   <= 1'b0;
      over      <= 1'b0;
      lead_bang <= 1'b0;
      pvalid    <= 1'b0;
      busy      <= 1'b0;
      len       <= '0;
      rem       <= '0;
      pos       <= '0;
      act       <= (L + 1)'(1);
      head      <= '0;
      star      <= '0;
      anyv      <= '0;
      neg       <= '0;
      member    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) begin
        v1        <= q_pop;
        v2        <= v1;
        out_valid <= emit;
      end
      if (q_pop && q_item.cmd == gpm_pkg::CMD_PATTERN && q_item.last) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (do_item) begin
        if (is_pat) begin
          pvalid    <= 1'b0;
          loading   <= !it2.last;
          len       <= len_n;
          over      <= over_n;
          lead_bang <= lead_bang_n;
          if (it2.last) begin
            rem    <= len_n;
            pos    <= '0;
            pstate <= gpm_pkg::PS_NORM;
            head   <= '0;
            star   <= '0;
            anyv   <= '0;
            neg    <= '0;
            member <= '0;
          end
        end else begin
          act <= it2.last ? initv : act_upd;
        end
      end
      if (sweep_step) begin
        head[pos]   <= w_head;
        star[pos]   <= w_star;
        anyv[pos]   <= w_any;
        neg[pos]    <= w_neg;
        member[pos] <= w_member;
        pstate      <= pstate_next;
        pos         <= pos + 1'b1;
        rem         <= rem - 1'b1;
      end
      if (finish) begin
        pvalid <= (st_code == gpm_pkg::ST_OK);
        act    <= initv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1  <= q_item;
      eq1  <= eq_d;
      it2  <= it1;
      acc2 <= acc_d;
    end
    if (do_item && is_pat && !it2.empty && eff_len < LW'(L)) begin
      store[eff_len[PW-1:0]] <= it2.cp;
      cls_q[eff_len[PW-1:0]] <= it2.cls;
    end else if (sweep_step) begin
      for (int j = 0; j < L - 1; j++) begin
        cls_q[j] <= cls_q[j+1];
      end
    end
    if (emit) begin
      out_kind    <= finish ? gpm_pkg::RK_LOAD : gpm_pkg::RK_VERDICT;
      out_status  <= finish ? st_code : gpm_pkg::ST_OK;
      out_matched <= !finish & pvalid & act_upd[len];
    end
  end

endmodule

// ===== hdl/glob_pattern_matcher_unit.sv =====
// Glob pattern matcher unit, top level: stream ports, front queue, matcher back end.
// Depends on gpm_pkg, gpm_front, gpm_back (and gpm_scan through gpm_back).
//
// Usage. Requests come in on the s_ group: tuser[0] selects pattern (0) or
// subject (1), tuser[1] marks an empty item, tlast ends a pattern or a subject.
// A pattern is loaded one codepoint per request; on its last request the block
// compiles it and returns one load status (m_tuser = 0). Each subject ending in
// tlast returns one verdict (m_tuser = 1, m_tdata[2] = matched).
// Throughput: one request per cycle for subjects and for pattern codepoints, while
// no result waits on m_tready. After the last pattern request the compiler walks the
// stored pattern one position per cycle, and issue pauses until the compile finishes.
// An accepted request passes through the queue, the compare stage, the span stage
// and the matcher into the result register.
// Reset clears the queue, the pipeline and the loaded pattern: until a pattern
// loads without error every subject yields matched = 0.
// When m_tready is low while a result waits, the result register holds and the back
// end stalls; the front queue keeps accepting until it is full, then s_tready drops.
module glob_pattern_matcher_unit #(
  parameter int PATTERN_LEN = gpm_pkg::PATTERN_LEN_DEF,
  parameter int QUEUE_DEPTH = gpm_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [gpm_pkg::IN_TDATA_W-1:0]     s_tdata,   // [20:0] codepoint
  input  logic                               s_tlast,   // is_last
  input  logic [1:0]                         s_tuser,   // [0] cmd, [1] is_empty
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [gpm_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [1:0] load_status, [2] matched
  output logic                               m_tuser    // result_kind
);

  logic                q_valid;
  logic                q_pop;
  gpm_pkg::item_t      q_item;
  gpm_pkg::kind_t      out_kind;
  gpm_pkg::load_st_t   out_status;
  logic                out_matched;
  gpm_pkg::bk_stat_t   stat;

  // front: accept, classify, queue
  gpm_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (s_tuser[0]),
    .in_cp    (s_tdata[gpm_pkg::CP_W-1:0]),
    .in_last  (s_tlast),
    .in_empty (s_tuser[1]),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // back: pattern store, compiler, matcher, result register
  gpm_back #(.PATTERN_LEN(PATTERN_LEN)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_kind    (out_kind),
    .out_status  (out_status),
    .out_matched (out_matched),
    .stat        (stat)
  );

  assign m_tdata = {{(gpm_pkg::OUT_TDATA_W - 3){1'b0}}, out_matched, out_status};
  assign m_tuser = out_kind;

`ifndef SYNTH
  // a verdict carries no status, a load status carries no match
  a_result_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser ? (m_tdata[1:0] == 2'b00) : !m_tdata[2]))
    else $error("result fields inconsistent with result kind");

  // the compiler only runs while issue is held off
  a_sweep_blocks: assert property (@(posedge clk) disable iff (rst)
    stat.sweep |-> stat.busy)
    else $error("compile sweep running with issue open");

  // ending a compile always returns a load status
  a_load_reported: assert property (@(posedge clk) disable iff (rst)
    ($fell(stat.busy) && !$past(rst)) |-> (m_tvalid && !m_tuser))
    else $error("compile finished without a load status");
`endif

endmodule
